/* src/cell_raster_draw_compositor_top_assert.svh */
`ifndef CELL_RASTER_DRAW_COMPOSITOR_TOP_ASSERT_SVH
`define CELL_RASTER_DRAW_COMPOSITOR_TOP_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define CRDC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("crdc check failed");

// Checks a property on every clock edge, reset included.
`define CRDC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("crdc check failed");

`endif

/* src/crdc_pkg.sv */
package crdc_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int CW     = 24;
  localparam int DEND_W = 8;
  localparam int DIV_W  = 7;
  localparam int RGB_W  = 24;

  localparam logic [2:0] OP_FILL  = 3'd0;
  localparam logic [2:0] OP_RECT  = 3'd1;
  localparam logic [2:0] OP_LINE  = 3'd2;
  localparam logic [2:0] OP_GUIDE = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  localparam logic [1:0] REG_FRAME_W = 2'd0;
  localparam logic [1:0] REG_FRAME_H = 2'd1;
  localparam logic [1:0] REG_CELL_W  = 2'd2;
  localparam logic [1:0] REG_CELL_H  = 2'd3;

  localparam logic [31:0] GRID_GREY    = 32'hFFE6E6E6;
  localparam logic [31:0] GUIDE_GREY   = 32'hFF969696;
  localparam logic [31:0] BG_EMPTY     = 32'h00FFFFFF;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [RGB_W-1:0] BLACK_RGB = 24'h000000;

  typedef struct packed {
    logic busy;
    logic rem_zero;
  } rem_stat_t;

endpackage

/* src/crdc_rem.sv */
module crdc_rem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [crdc_pkg::DEND_W-1:0]  dividend,
  input  logic [crdc_pkg::DIV_W-1:0]   divisor,
  output crdc_pkg::rem_stat_t          stat
);

  localparam int CNT_W = $clog2(crdc_pkg::DEND_W);

  logic                        busy_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [crdc_pkg::DEND_W-1:0] dend_r;
  logic [crdc_pkg::DIV_W-1:0]  rem_r;
  logic [crdc_pkg::DIV_W-1:0]  rem_nxt;
  logic [crdc_pkg::DIV_W:0]    trial;
  logic [crdc_pkg::DIV_W:0]    diff;

  // One restoring step per cycle, most significant dividend bit first.
  always_comb begin
    trial = {rem_r, dend_r[crdc_pkg::DEND_W-1]};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      rem_nxt = diff[crdc_pkg::DIV_W-1:0];
    end else begin
      rem_nxt = trial[crdc_pkg::DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dend_r <= dividend;
      rem_r  <= '0;
      cnt_r  <= CNT_W'(crdc_pkg::DEND_W - 1);
    end else if (busy_r) begin
      dend_r <= {dend_r[crdc_pkg::DEND_W-2:0], 1'b0};
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign stat.busy     = busy_r;
  assign stat.rem_zero = (rem_r == '0);

endmodule

/* src/cell_raster_draw_compositor_top.sv */
// Pixel read: the transfer in starts both 8-step remainders alongside the multiply, and
// the result is registered once both finish. Drawing: result in the cycle after the transfer
// in; the block then steps through S_MUL, S_BOX and S_CLIP and walks the clipped area at one
// pixel per cycle through the single write port of the pixel memory. Guideline, unknown and
// no-op commands: result in the cycle after the transfer in. Reset and clear: a clearing pass
// over 2^(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) entries, taking no item. Reset is synchronous.
`include "cell_raster_draw_compositor_top_assert.svh"

module cell_raster_draw_compositor_top #(
  parameter int MAX_WIDTH  = crdc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = crdc_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic signed [11:0] in_cell_col,
  input  logic signed [11:0] in_cell_row,
  input  logic [11:0] in_span_cells,
  input  logic [23:0] in_draw_color,
  input  logic [7:0]  in_pixel_x,
  input  logic [7:0]  in_pixel_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pixel_word,
  output logic        out_is_read,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int CW    = crdc_pkg::CW;
  localparam int XB    = $clog2(MAX_WIDTH);
  localparam int YB    = $clog2(MAX_HEIGHT);
  localparam int AW    = XB + YB;
  localparam int DEPTH = 1 << AW;
  localparam int MW    = crdc_pkg::RGB_W + 1;
  localparam logic signed [CW-1:0] MAXW_C = CW'(MAX_WIDTH);
  localparam logic signed [CW-1:0] MAXH_C = CW'(MAX_HEIGHT);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_BOX    = 3'd3;
  localparam logic [2:0] S_CLIP   = 3'd4;
  localparam logic [2:0] S_WALK   = 3'd5;
  localparam logic [2:0] S_RDWAIT = 3'd6;

  logic [2:0] state_r;
  logic [AW-1:0] clr_cnt_r;

  logic [8:0] fw_r, fh_r;
  logic [6:0] cwid_r, chgt_r;

  logic guide_on_r;
  logic signed [11:0] gcol_r, grow_r;

  logic [2:0] op_r;
  logic signed [11:0] col_r, row_r;
  logic [11:0] span_r;
  logic [23:0] rgb_r;
  logic [7:0] px_r, py_r;

  logic signed [CW-1:0] xb_r, xe_r, yb_r, ye_r;
  logic signed [CW-1:0] bx0_r, bx1_r, by0_r, by1_r;
  logic skip_r;
  logic signed [CW-1:0] cx0_r, cx1_r, cy1_r, wx_r, wy_r;

  logic        out_valid_r;
  logic [31:0] pixel_word_r;
  logic        is_read_r;

  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] mem_q_r;

  logic signed [CW-1:0] w_e, h_e, cw_e, ch_e;
  logic signed [CW-1:0] colspan, a0, a1, r0, r1;
  logic signed [CW-1:0] bx0_nxt, bx1_nxt, by0_nxt, by1_nxt;
  logic skip_nxt;
  logic signed [CW-1:0] cx0_nxt, cx1_nxt, cy0_nxt, cy1_nxt;
  logic signed [CW-1:0] xs, ys;
  logic accept, rd_go, on_border, grid_hit, guide_hit, in_frame;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [MW-1:0] wdata;
  logic [31:0] word_nxt;
  logic signed [CW-1:0] px_ext, py_ext;
  crdc_pkg::rem_stat_t rx_stat, ry_stat;

  assign w_e  = ($signed({{(CW-9){1'b0}}, fw_r}) > MAXW_C) ? MAXW_C
              : $signed({{(CW-9){1'b0}}, fw_r});
  assign h_e  = ($signed({{(CW-9){1'b0}}, fh_r}) > MAXH_C) ? MAXH_C
              : $signed({{(CW-9){1'b0}}, fh_r});
  assign cw_e = (cwid_r == '0) ? CW'(1) : $signed({{(CW-7){1'b0}}, cwid_r});
  assign ch_e = (chgt_r == '0) ? CW'(1) : $signed({{(CW-7){1'b0}}, chgt_r});

  assign accept    = in_valid && !in_stall;
  assign rd_go     = accept && in_op == crdc_pkg::OP_READ;
  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= 9'd256;
      fh_r   <= 9'd256;
      cwid_r <= 7'd4;
      chgt_r <= 7'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        crdc_pkg::REG_FRAME_W: fw_r   <= cfg_data;
        crdc_pkg::REG_FRAME_H: fh_r   <= cfg_data;
        crdc_pkg::REG_CELL_W:  cwid_r <= cfg_data[6:0];
        crdc_pkg::REG_CELL_H:  chgt_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    colspan = CW'(col_r) + $signed({{(CW-12){1'b0}}, span_r});
    if (op_r == crdc_pkg::OP_READ) begin
      a0 = CW'(gcol_r);
      a1 = CW'(gcol_r) + CW'(1);
      r0 = CW'(grow_r);
    end else begin
      a0 = CW'(col_r);
      a1 = colspan;
      r0 = CW'(row_r);
    end
    r1 = r0 + CW'(1);
  end

  always_comb begin
    bx0_nxt  = xb_r;
    bx1_nxt  = xb_r + cw_e - CW'(1);
    by0_nxt  = yb_r;
    by1_nxt  = yb_r + ch_e - CW'(1);
    skip_nxt = row_r < 0;
    case (op_r)
      crdc_pkg::OP_FILL: ;
      crdc_pkg::OP_RECT: begin
        if (xe_r - CW'(1) < xb_r) begin
          bx0_nxt = xe_r - CW'(1);
          bx1_nxt = xb_r;
        end else begin
          bx0_nxt = xb_r;
          bx1_nxt = xe_r - CW'(1);
        end
        by1_nxt  = ye_r - CW'(1);
        skip_nxt = (colspan < 0) || (row_r < 0);
      end
      default: begin
        bx0_nxt  = '0;
        bx1_nxt  = w_e - CW'(1);
        by0_nxt  = ye_r;
        by1_nxt  = ye_r;
        skip_nxt = (ye_r < 0) || (ye_r > h_e);
      end
    endcase
  end

  always_comb begin
    cx0_nxt = (bx0_r < 0) ? '0 : bx0_r;
    cy0_nxt = (by0_r < 0) ? '0 : by0_r;
    cx1_nxt = (bx1_r > w_e - CW'(1)) ? w_e - CW'(1) : bx1_r;
    cy1_nxt = (by1_r > h_e - CW'(1)) ? h_e - CW'(1) : by1_r;
  end

  assign on_border = (op_r == crdc_pkg::OP_RECT) &&
                     (wx_r == xb_r || wx_r == xe_r - CW'(1) ||
                      wy_r == yb_r || wy_r == ye_r - CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_cnt_r  <= '0;
      guide_on_r <= 1'b0;
      gcol_r     <= '0;
      grow_r     <= '0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == {AW{1'b1}}) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (in_op)
              crdc_pkg::OP_FILL, crdc_pkg::OP_RECT, crdc_pkg::OP_LINE,
              crdc_pkg::OP_READ: state_r <= S_MUL;
              crdc_pkg::OP_GUIDE: begin
                gcol_r     <= in_cell_col;
                grow_r     <= in_cell_row;
                guide_on_r <= 1'b1;
              end
              crdc_pkg::OP_CLEAR: begin
                guide_on_r <= 1'b0;
                clr_cnt_r  <= '0;
                state_r    <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end
        S_MUL: state_r <= (op_r == crdc_pkg::OP_READ) ? S_RDWAIT : S_BOX;
        S_BOX: state_r <= S_CLIP;
        S_CLIP: begin
          if (skip_r || cx0_nxt > cx1_nxt || cy0_nxt > cy1_nxt) begin
            state_r <= S_IDLE;
          end else begin
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          if (wx_r == cx1_r && wy_r == cy1_r) begin
            state_r <= S_IDLE;
          end
        end
        S_RDWAIT: begin
          if (!rx_stat.busy && !ry_stat.busy) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      col_r  <= in_cell_col;
      row_r  <= in_cell_row;
      span_r <= in_span_cells;
      rgb_r  <= in_draw_color;
      px_r   <= in_pixel_x;
      py_r   <= in_pixel_y;
    end
    if (state_r == S_MUL) begin
      xb_r <= a0 * cw_e;
      xe_r <= a1 * cw_e;
      yb_r <= r0 * ch_e;
      ye_r <= r1 * ch_e;
    end
    if (state_r == S_BOX) begin
      bx0_r  <= bx0_nxt;
      bx1_r  <= bx1_nxt;
      by0_r  <= by0_nxt;
      by1_r  <= by1_nxt;
      skip_r <= skip_nxt;
    end
    if (state_r == S_CLIP) begin
      cx0_r <= cx0_nxt;
      cx1_r <= cx1_nxt;
      cy1_r <= cy1_nxt;
      wx_r  <= cx0_nxt;
      wy_r  <= cy0_nxt;
    end else if (state_r == S_WALK) begin
      if (wx_r == cx1_r) begin
        wx_r <= cx0_r;
        wy_r <= wy_r + CW'(1);
      end else begin
        wx_r <= wx_r + CW'(1);
      end
    end
  end

  assign we    = (state_r == S_WALK) || (state_r == S_CLEAR);
  assign waddr = (state_r == S_CLEAR) ? clr_cnt_r : {wy_r[YB-1:0], wx_r[XB-1:0]};
  assign wdata = (state_r == S_CLEAR) ? '0
               : {1'b1, on_border ? crdc_pkg::BLACK_RGB : rgb_r};
  assign px_ext = CW'(in_pixel_x);
  assign py_ext = CW'(in_pixel_y);
  assign raddr  = {py_ext[YB-1:0], px_ext[XB-1:0]};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_go) begin
      mem_q_r <= mem[raddr];
    end
  end

  crdc_rem u_rem_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rd_go),
    .dividend (in_pixel_x),
    .divisor  (ch_e[crdc_pkg::DIV_W-1:0]),
    .stat     (rx_stat)
  );

  crdc_rem u_rem_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rd_go),
    .dividend (in_pixel_y),
    .divisor  (ch_e[crdc_pkg::DIV_W-1:0]),
    .stat     (ry_stat)
  );

  always_comb begin
    xs        = CW'(px_r);
    ys        = CW'(py_r);
    in_frame  = (xs < w_e) && (ys < h_e);
    grid_hit  = (ys >= ch_e && ry_stat.rem_zero && w_e > ch_e && xs + CW'(2) <= w_e) ||
                (xs >= ch_e && rx_stat.rem_zero && h_e > ch_e && ys + CW'(2) <= h_e);
    guide_hit = guide_on_r && (ys == yb_r || ys == ye_r || xs == xb_r || xs == xe_r);
    if (!in_frame) begin
      word_nxt = '0;
    end else if (guide_hit) begin
      word_nxt = crdc_pkg::GUIDE_GREY;
    end else if (mem_q_r[MW-1]) begin
      word_nxt = {crdc_pkg::ALPHA_OPAQUE, mem_q_r[crdc_pkg::RGB_W-1:0]};
    end else if (grid_hit) begin
      word_nxt = crdc_pkg::GRID_GREY;
    end else begin
      word_nxt = crdc_pkg::BG_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_op != crdc_pkg::OP_READ) begin
      out_valid_r <= 1'b1;
    end else if (state_r == S_RDWAIT && !rx_stat.busy && !ry_stat.busy) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_op != crdc_pkg::OP_READ) begin
      pixel_word_r <= '0;
      is_read_r    <= 1'b0;
    end else if (state_r == S_RDWAIT && !rx_stat.busy && !ry_stat.busy) begin
      pixel_word_r <= word_nxt;
      is_read_r    <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_word = pixel_word_r;
  assign out_is_read    = is_read_r;

  `CRDC_ASSERT(a_walk_in_frame, (state_r == S_WALK) |-> (wx_r >= 0 && wx_r < w_e && wy_r >= 0 && wy_r < h_e))
  `CRDC_ASSERT(a_read_starts_rem, rd_go |=> (rx_stat.busy && ry_stat.busy && state_r == S_MUL))
  `CRDC_ASSERT(a_clear_ends, (state_r == S_CLEAR && clr_cnt_r == {AW{1'b1}}) |=> (state_r == S_IDLE))
  `CRDC_ASSERT(a_no_take_busy, (state_r == S_WALK || state_r == S_RDWAIT) |-> in_stall)

endmodule

/* sim/crdc_checker.sv */
module crdc_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         in_op,
  input  logic signed [11:0] in_cell_col,
  input  logic signed [11:0] in_cell_row,
  input  logic [11:0]        in_span_cells,
  input  logic [23:0]        in_draw_color,
  input  logic [7:0]         in_pixel_x,
  input  logic [7:0]         in_pixel_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [31:0]        out_pixel_word,
  input  logic               out_is_read,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [31:0] word;
    logic        is_read;
  } pixel_result_t;

  localparam int MW = crdc_pkg::DEF_MAX_WIDTH;
  localparam int MH = crdc_pkg::DEF_MAX_HEIGHT;

  logic [24:0] canvas [MW*MH];
  logic [8:0]  frame_w, frame_h;
  logic [6:0]  cell_w, cell_h;
  logic        guides_on;
  longint      guide_c, guide_r;
  pixel_result_t awaited_pixels[$];
  int          fails = 0;

  assign pending = awaited_pixels.size();
  assign fail_count = fails;

  function automatic longint ew();
    return (frame_w > MW) ? MW : longint'(frame_w);
  endfunction

  function automatic longint eh();
    return (frame_h > MH) ? MH : longint'(frame_h);
  endfunction

  function automatic longint ecw();
    return (cell_w == 0) ? 1 : longint'(cell_w);
  endfunction

  function automatic longint ech();
    return (cell_h == 0) ? 1 : longint'(cell_h);
  endfunction

  function automatic longint lo0(longint a);
    return (a < 0) ? 0 : a;
  endfunction

  function automatic longint himax(longint a, longint m);
    return (a > m) ? m : a;
  endfunction

  function automatic void plot(longint x, longint y, logic [23:0] rgb);
    if (x >= 0 && y >= 0 && x < ew() && y < eh())
      canvas[y*MW + x] = {1'b1, rgb};
  endfunction

  function automatic void wipe_canvas();
    foreach (canvas[i]) canvas[i] = '0;
  endfunction

  function automatic void paint_cell(longint col, longint row, logic [23:0] rgb);
    longint x0, y0;
    x0 = col * ecw();
    y0 = row * ech();
    if (row < 0) return;
    for (longint x = lo0(x0); x < himax(x0 + ecw(), ew()); x++)
      for (longint y = lo0(y0); y < himax(y0 + ech(), eh()); y++)
        plot(x, y, rgb);
  endfunction

  function automatic void paint_box(longint col, longint span, longint row,
                                    logic [23:0] rgb);
    longint xb, xe, yb, ye;
    if (col + span < 0 || row < 0) return;
    xb = col * ecw();
    xe = (col + span) * ecw();
    yb = row * ech();
    ye = (row + 1) * ech();
    for (longint x = lo0(xb); x < himax(xe, ew()); x++) begin
      plot(x, yb, crdc_pkg::BLACK_RGB);
      plot(x, ye - 1, crdc_pkg::BLACK_RGB);
    end
    for (longint y = lo0(yb); y < himax(ye, eh()); y++) begin
      plot(xb, y, crdc_pkg::BLACK_RGB);
      plot(xe - 1, y, crdc_pkg::BLACK_RGB);
    end
    for (longint x = lo0(xb + 1); x < himax(xe - 1, ew()); x++)
      for (longint y = lo0(yb + 1); y < himax(ye - 1, eh()); y++)
        plot(x, y, rgb);
  endfunction

  function automatic void paint_row(longint row, logic [23:0] rgb);
    longint y;
    y = (row + 1) * ech();
    if (y < 0 || y > eh()) return;
    for (longint x = 0; x < ew(); x++)
      plot(x, y, rgb);
  endfunction

  function automatic logic [31:0] composed_pixel(longint x, longint y);
    logic [31:0] px;
    logic [24:0] m;
    longint w, h, cw, ch;
    w = ew();
    h = eh();
    cw = ecw();
    ch = ech();
    px = crdc_pkg::BG_EMPTY;
    if (x >= w || y >= h) return 32'd0;
    if (y >= ch && y % ch == 0 && w > ch && x <= w - 2) px = crdc_pkg::GRID_GREY;
    if (x >= ch && x % ch == 0 && h > ch && y <= h - 2) px = crdc_pkg::GRID_GREY;
    m = canvas[y*MW + x];
    if (m[24]) px = {crdc_pkg::ALPHA_OPAQUE, m[23:0]};
    if (guides_on && (y == guide_r * ch || y == (guide_r + 1) * ch ||
                      x == guide_c * cw || x == (guide_c + 1) * cw))
      px = crdc_pkg::GUIDE_GREY;
    return px;
  endfunction

  always @(posedge clk) begin
    pixel_result_t exp_px;
    if (!rst_n) begin
      wipe_canvas();
      frame_w = 9'd256;
      frame_h = 9'd256;
      cell_w = 7'd4;
      cell_h = 7'd4;
      guides_on = 1'b0;
      guide_c = 0;
      guide_r = 0;
      awaited_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          crdc_pkg::REG_FRAME_W: frame_w = cfg_data;
          crdc_pkg::REG_FRAME_H: frame_h = cfg_data;
          crdc_pkg::REG_CELL_W:  cell_w = cfg_data[6:0];
          crdc_pkg::REG_CELL_H:  cell_h = cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (awaited_pixels.size() == 0) begin
          $error("unexpected result transfer: pixel_word %h is_read %b",
                 out_pixel_word, out_is_read);
          fails++;
        end else begin
          exp_px = awaited_pixels.pop_front();
          if (out_pixel_word !== exp_px.word) begin
            $error("pixel_word mismatch: expected %h, actual %h",
                   exp_px.word, out_pixel_word);
            fails++;
          end
          if (out_is_read !== exp_px.is_read) begin
            $error("is_read mismatch: expected %b, actual %b",
                   exp_px.is_read, out_is_read);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        exp_px = '0;
        case (in_op)
          crdc_pkg::OP_FILL:  paint_cell(in_cell_col, in_cell_row, in_draw_color);
          crdc_pkg::OP_RECT:  paint_box(in_cell_col, longint'(in_span_cells), in_cell_row,
                                        in_draw_color);
          crdc_pkg::OP_LINE:  paint_row(in_cell_row, in_draw_color);
          crdc_pkg::OP_GUIDE: begin
            guide_c = in_cell_col;
            guide_r = in_cell_row;
            guides_on = 1'b1;
          end
          crdc_pkg::OP_CLEAR: begin
            wipe_canvas();
            guides_on = 1'b0;
          end
          crdc_pkg::OP_READ: begin
            exp_px.word = composed_pixel(in_pixel_x, in_pixel_y);
            exp_px.is_read = 1'b1;
          end
          default: ;
        endcase
        awaited_pixels.push_back(exp_px);
      end
    end
  end

endmodule

/* sim/cell_raster_draw_compositor_top_tb.sv */
module cell_raster_draw_compositor_top_tb;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_op = '0;
  logic signed [11:0] in_cell_col = '0;
  logic signed [11:0] in_cell_row = '0;
  logic [11:0]        in_span_cells = '0;
  logic [23:0]        in_draw_color = '0;
  logic [7:0]         in_pixel_x = '0;
  logic [7:0]         in_pixel_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        out_pixel_word;
  logic               out_is_read;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [8:0]         cfg_data = '0;

  int fail_count;
  int pending;
  bit calm = 1'b0;
  int cur_fw, cur_fh, cur_cw, cur_ch;
  longint cycles = 0;

  cell_raster_draw_compositor_top dut (.*);

  crdc_checker checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 64'd6000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (calm) begin
        out_stall <= 1'b0;
        @(negedge clk);
      end else begin
        n = $urandom_range(1, 18);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        n = $urandom_range(1, 40);
        out_stall <= 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[8:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_cmd(logic [2:0] op, int col, int row, int span, int rgb,
                          int px, int py);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_cell_col <= col[11:0];
    in_cell_row <= row[11:0];
    in_span_cells <= span[11:0];
    in_draw_color <= rgb[23:0];
    in_pixel_x <= px[7:0];
    in_pixel_y <= py[7:0];
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // The block is idle once every result is out and it takes transfers again.
  task automatic settle_and_set(int fw, int fh, int cw, int ch);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    while (in_stall) @(negedge clk);
    write_reg(crdc_pkg::REG_FRAME_W, fw);
    write_reg(crdc_pkg::REG_FRAME_H, fh);
    write_reg(crdc_pkg::REG_CELL_W, cw);
    write_reg(crdc_pkg::REG_CELL_H, ch);
    cur_fw = fw;
    cur_fh = fh;
    cur_cw = (cw == 0) ? 1 : cw;
    cur_ch = (ch == 0) ? 1 : ch;
  endtask

  function automatic int pick_coord(int lim, int unit);
    if ($urandom_range(0, 6) == 0) return $urandom_range(0, 4095);
    return $signed($urandom_range(0, lim / unit + 3)) - 2;
  endfunction

  task automatic random_cmd();
    int sel, lim_x, lim_y, col, row, span, px, py;
    logic [2:0] op;
    sel = $urandom_range(0, 399);
    if (sel < 160) op = crdc_pkg::OP_READ;
    else if (sel < 240) op = crdc_pkg::OP_FILL;
    else if (sel < 300) op = crdc_pkg::OP_RECT;
    else if (sel < 335) op = crdc_pkg::OP_LINE;
    else if (sel < 370) op = crdc_pkg::OP_GUIDE;
    else if (sel < 397) op = 3'($urandom_range(6, 7));
    else op = crdc_pkg::OP_CLEAR;
    lim_x = (cur_fw > 256) ? 256 : cur_fw;
    lim_y = (cur_fh > 256) ? 256 : cur_fh;
    col = pick_coord(lim_x, cur_cw);
    row = pick_coord(lim_y, cur_ch);
    span = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 6);
    if ($urandom_range(0, 2) != 0 && lim_x > 0 && lim_y > 0) begin
      px = $urandom_range(0, lim_x - 1);
      py = $urandom_range(0, lim_y - 1);
    end else begin
      px = $urandom_range(0, 255);
      py = $urandom_range(0, 255);
    end
    send_cmd(op, col, row, span, $urandom_range(0, 24'hFFFFFF), px, py);
  endtask

  initial begin
    static int cfgs [7][4] = '{'{256, 256, 4, 4}, '{256, 256, 1, 1}, '{0, 0, 64, 64},
                               '{511, 511, 127, 127}, '{300, 17, 0, 0}, '{40, 30, 7, 5},
                               '{256, 256, 64, 64}};
    int issued;
    cur_fw = 256;
    cur_fh = 256;
    cur_cw = 4;
    cur_ch = 4;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    settle_and_set(256, 256, 4, 4);
    send_cmd(crdc_pkg::OP_FILL, 0, 0, 0, 24'hFFFFFF, 0, 0);
    send_cmd(crdc_pkg::OP_FILL, -1, 2, 0, 24'h123456, 0, 0);
    send_cmd(crdc_pkg::OP_FILL, 3, -1, 0, 24'hABCDEF, 0, 0);
    send_cmd(crdc_pkg::OP_FILL, 2047, 2047, 0, 24'h000000, 0, 0);
    send_cmd(crdc_pkg::OP_RECT, 2, 3, 0, 24'h00FF00, 0, 0);
    send_cmd(crdc_pkg::OP_RECT, -2048, 1, 4095, 24'hFF0000, 0, 0);
    send_cmd(crdc_pkg::OP_RECT, -5, 1, 3, 24'h0000FF, 0, 0);
    send_cmd(crdc_pkg::OP_RECT, 1, 5, 4, 24'h55AA55, 0, 0);
    send_cmd(crdc_pkg::OP_LINE, 0, -1, 0, 24'h808080, 0, 0);
    send_cmd(crdc_pkg::OP_LINE, 0, 63, 0, 24'h010203, 0, 0);
    send_cmd(crdc_pkg::OP_LINE, 0, -2048, 0, 24'h010203, 0, 0);
    send_cmd(crdc_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
    send_cmd(crdc_pkg::OP_READ, 0, 0, 0, 0, 9, 21);
    send_cmd(crdc_pkg::OP_READ, 0, 0, 0, 0, 4, 4);
    send_cmd(crdc_pkg::OP_READ, 0, 0, 0, 0, 255, 255);
    send_cmd(crdc_pkg::OP_READ, 0, 0, 0, 0, 254, 8);
    send_cmd(crdc_pkg::OP_GUIDE, 2, 3, 0, 0, 0, 0);
    send_cmd(crdc_pkg::OP_READ, 0, 0, 0, 0, 12, 100);
    send_cmd(crdc_pkg::OP_READ, 0, 0, 0, 0, 100, 16);
    send_cmd(3'd6, 0, 0, 0, 24'hFFFFFF, 0, 0);
    send_cmd(3'd7, -1, -1, 4095, 24'hFFFFFF, 255, 255);
    send_cmd(crdc_pkg::OP_GUIDE, -2048, 2047, 0, 0, 0, 0);
    send_cmd(crdc_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0);
    send_cmd(crdc_pkg::OP_READ, 0, 0, 0, 0, 9, 21);
    send_cmd(crdc_pkg::OP_READ, 0, 0, 0, 0, 1, 4);

    issued = 0;
    for (int p = 0; p < 7; p++) begin
      if (p != 0) settle_and_set(cfgs[p][0], cfgs[p][1], cfgs[p][2], cfgs[p][3]);
      for (int i = 0; i < 104; i++) begin
        if (issued > 640) calm = 1'b1;
        random_cmd();
        issued++;
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
